FILE: rtl/ddc_pkg.sv
package ddc_pkg;

  // sample timestamp and register widths
  localparam int TimeW     = 32;
  localparam int MsCfgW    = 16;
  localparam int CfgIndexW = 4;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_APPEAR_TIMEOUT = 4'd0;
  localparam logic [CfgIndexW-1:0] CFG_COOLDOWN       = 4'd1;

  // register reset values
  localparam logic [MsCfgW-1:0] APPEAR_TIMEOUT_RESET = 16'd1000;
  localparam logic [MsCfgW-1:0] COOLDOWN_RESET       = 16'd500;

  // side codes
  localparam logic SIDE_INSIDE  = 1'b0;
  localparam logic SIDE_OUTSIDE = 1'b1;

  // count change codes
  localparam logic signed [1:0] COUNT_NONE  = 2'sd0;
  localparam logic signed [1:0] COUNT_ENTER = 2'sd1;
  localparam logic signed [1:0] COUNT_LEAVE = -2'sd1;

  typedef enum logic [1:0] {
    STAGE_IDLE    = 2'd0,
    STAGE_FIRST   = 2'd1,
    STAGE_BOTH    = 2'd2,
    STAGE_CLEARED = 2'd3
  } stage_t;

  typedef struct packed {
    stage_t           stage;
    logic             first_side;
    logic             cleared_side;
    logic [TimeW-1:0] appear_time;
    logic [TimeW-1:0] finish_time;
  } ddc_state_t;

  typedef struct packed {
    logic [MsCfgW-1:0] appear_timeout_ms;
    logic [MsCfgW-1:0] cooldown_ms;
  } ddc_cfg_t;

endpackage

FILE: rtl/ddc_step.sv
module ddc_step import ddc_pkg::*; (
  input  ddc_state_t        cur,
  input  ddc_cfg_t          cfg,
  input  logic              inside_seen,
  input  logic              outside_seen,
  input  logic [TimeW-1:0]  now_ms,
  output ddc_state_t        nxt,
  output logic signed [1:0] count_change
);

  logic [TimeW-1:0] since_finish;
  logic [TimeW-1:0] since_appear;
  logic             in_cooldown;
  logic             timed_out;
  logic             mine;
  logic             other;
  logic             both_clear;

  // elapsed times, modulo 2^32
  assign since_finish = now_ms - cur.finish_time;
  assign since_appear = now_ms - cur.appear_time;
  assign in_cooldown  = since_finish < {{(TimeW-MsCfgW){1'b0}}, cfg.cooldown_ms};
  assign timed_out    = since_appear > {{(TimeW-MsCfgW){1'b0}}, cfg.appear_timeout_ms};

  // first sensor and the opposite one
  assign mine       = (cur.first_side == SIDE_INSIDE) ? inside_seen : outside_seen;
  assign other      = (cur.first_side == SIDE_INSIDE) ? outside_seen : inside_seen;
  assign both_clear = !inside_seen && !outside_seen;

  // next sequence state
  always_comb begin
    nxt = cur;
    unique case (cur.stage)
      STAGE_IDLE: begin
        if (!in_cooldown) begin
          nxt.appear_time = now_ms;
          if (inside_seen) begin
            nxt.first_side = SIDE_INSIDE;
            nxt.stage      = STAGE_FIRST;
          end else if (outside_seen) begin
            nxt.first_side = SIDE_OUTSIDE;
            nxt.stage      = STAGE_FIRST;
          end
        end
      end
      STAGE_FIRST: begin
        if (other) begin
          nxt.stage = STAGE_BOTH;
        end else if (!mine) begin
          if (timed_out) begin
            nxt.stage = STAGE_IDLE;
          end
        end else begin
          nxt.appear_time = now_ms;
        end
      end
      STAGE_BOTH: begin
        if (!inside_seen) begin
          nxt.cleared_side = SIDE_INSIDE;
          nxt.stage        = STAGE_CLEARED;
        end else if (!outside_seen) begin
          nxt.cleared_side = SIDE_OUTSIDE;
          nxt.stage        = STAGE_CLEARED;
        end
      end
      STAGE_CLEARED: begin
        if (inside_seen) begin
          if (cur.cleared_side == SIDE_INSIDE) begin
            nxt.stage = STAGE_BOTH;
          end
        end else if (outside_seen) begin
          if (cur.cleared_side == SIDE_OUTSIDE) begin
            nxt.stage = STAGE_BOTH;
          end
        end else begin
          nxt.stage = STAGE_IDLE;
          if (cur.cleared_side == cur.first_side) begin
            nxt.finish_time = now_ms;
          end
        end
      end
      default: nxt = cur;
    endcase
  end

  // count on a completed pass
  always_comb begin
    count_change = COUNT_NONE;
    unique case (cur.stage)
      STAGE_CLEARED: begin
        if (both_clear && (cur.cleared_side == cur.first_side)) begin
          count_change = (cur.first_side == SIDE_OUTSIDE) ? COUNT_ENTER : COUNT_LEAVE;
        end
      end
      default: count_change = COUNT_NONE;
    endcase
  end

endmodule

FILE: rtl/doorway_direction_counter_core.sv
// Two-sensor doorway counter: each sample of the inside and outside sensors, with its
// millisecond timestamp, yields one signed count change (+1 entered, -1 left, 0 nothing).
// One sample is accepted every clock cycle while in_ready is high; its result appears in the output register on
// the next cycle and in_ready stays high while that register is empty or being drained.
// The sequence update is combinational: two 32-bit timestamp subtracts, compared against the
// cooldown and the appear timeout, then the stage register update.
// Timeout and cooldown registers may be written only while no sample is in flight.
module doorway_direction_counter_core import ddc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 inside_seen,
  input  logic                 outside_seen,
  input  logic [TimeW-1:0]     now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [1:0]    count_change,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [MsCfgW-1:0]    cfg_data
);

  ddc_state_t        state;
  ddc_state_t        state_next;
  ddc_cfg_t          cfg;
  logic signed [1:0] step_count;
  logic              in_fire;
  logic              cfg_fire;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.appear_timeout_ms <= APPEAR_TIMEOUT_RESET;
      cfg.cooldown_ms       <= COOLDOWN_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_APPEAR_TIMEOUT: cfg.appear_timeout_ms <= cfg_data;
        CFG_COOLDOWN:       cfg.cooldown_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequence update logic
  ddc_step u_step (
    .cur          (state),
    .cfg          (cfg),
    .inside_seen  (inside_seen),
    .outside_seen (outside_seen),
    .now_ms       (now_ms),
    .nxt          (state_next),
    .count_change (step_count)
  );

  // sequence state, advanced once per input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state.stage        <= STAGE_IDLE;
      state.first_side   <= SIDE_INSIDE;
      state.cleared_side <= SIDE_INSIDE;
      state.appear_time  <= '0;
      state.finish_time  <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      count_change <= step_count;
    end
  end

`ifndef ASSERT_OFF
  // an accepted sample always leaves a result behind
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted sample produced no result");

  // a counted pass closes the sequence and starts the cooldown
  a_count_closes: assert property (@(posedge clk) disable iff (rst)
    (in_fire && step_count != COUNT_NONE) |=>
      (state.stage == STAGE_IDLE && state.finish_time == $past(now_ms)))
    else $error("counted pass did not restart the sequence");

  // only a pass from the cleared stage can count
  a_count_source: assert property (@(posedge clk) disable iff (rst)
    (step_count != COUNT_NONE) |-> (state.stage == STAGE_CLEARED))
    else $error("count outside the cleared stage");

  // the sequence state moves only with an input transaction
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(state))
    else $error("sequence state changed without a transaction");

  // the result is never the unused code
  a_count_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count_change != 2'sb10))
    else $error("invalid count change code");
`endif

endmodule
